// ----- design/serial_packet_deframer_crc8_defines.svh -----
// Assertion macros shared by the deframer RTL.
`ifndef SERIAL_PACKET_DEFRAMER_CRC8_DEFINES_SVH
`define SERIAL_PACKET_DEFRAMER_CRC8_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SPDC8_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SPDC8_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/spdc8_pkg.sv -----
// Shared constants, types and the CRC-8 step for the serial packet deframer.
package spdc8_pkg;

   localparam int BODY_LIMIT_DEFAULT = 64;

   localparam logic [7:0] SYNC_BYTE      = 8'h55;
   localparam logic [7:0] CRC_POLY       = 8'h07;
   localparam logic [7:0] TYPE_RADIO_ADV = 8'h0A;
   localparam logic [7:0] ORG_TEACH      = 8'h62;
   localparam logic [7:0] ORG_RPS        = 8'h20;
   localparam logic [7:0] ORG_4BS        = 8'h22;
   localparam logic [3:0] RPS_DATA_MASK  = 4'hF;

   localparam int LEAD_DEPTH = 11;
   localparam int LEAD_IW    = $clog2(LEAD_DEPTH);
   localparam int HDR_DEPTH  = 4;

   // Deframer phase, one-hot
   typedef enum logic [2:0] {
      PH_HUNT   = 3'b001,
      PH_HEADER = 3'b010,
      PH_BODY   = 3'b100
   } phase_type;

   // One result word
   typedef struct packed {
      logic [7:0]  packet_type;
      logic [15:0] data_length;
      logic [7:0]  optional_length;
      logic        body_crc_ok;
      logic        radio_valid;
      logic [7:0]  radio_org;
      logic [31:0] sender_id;
      logic [31:0] payload_word;
      logic        repeat_bit;
   } rsp_word_type;

   // CRC-8, poly 0x07, MSB first, one byte
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

// ----- design/spdc8_intf.sv -----
// Valid/ready channel interfaces for the deframer's byte input and result output.
interface spdc8_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface spdc8_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  packet_type;
   logic [15:0] data_length;
   logic [7:0]  optional_length;
   logic        body_crc_ok;
   logic        radio_valid;
   logic [7:0]  radio_org;
   logic [31:0] sender_id;
   logic [31:0] payload_word;
   logic        repeat_bit;

   modport source (output valid, output packet_type, output data_length,
                   output optional_length, output body_crc_ok, output radio_valid,
                   output radio_org, output sender_id, output payload_word,
                   output repeat_bit, input ready);
   modport sink   (input valid, input packet_type, input data_length,
                   input optional_length, input body_crc_ok, input radio_valid,
                   input radio_org, input sender_id, input payload_word,
                   input repeat_bit, output ready);
endinterface

// ----- design/serial_packet_deframer_crc8.sv -----
// Serial packet deframer: sync hunt, CRC-8 checked header and body, radio field decode.
//
//  Channel   Dir  Word                      Handshake
//  req_chan  in   rx_byte (8)               valid/ready
//  rsp_chan  out  header fields, CRC flag,  valid/ready
//                 decoded radio fields
//
// One byte is taken every cycle unless the skid entry is full; each byte is handled in
// the cycle it is accepted, and the result of a packet's last body byte is registered.
// Two result words can be held (output register plus a skid entry); req_chan.ready
// drops only while the skid entry is full, i.e. when the result side stalls.
// Synchronous active-high reset returns to sync hunting with both result slots empty.
`include "serial_packet_deframer_crc8_defines.svh"

module serial_packet_deframer_crc8 #(
   parameter int BODY_LIMIT = spdc8_pkg::BODY_LIMIT_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   spdc8_req_if.sink         req_chan,
   spdc8_rsp_if.source       rsp_chan
);
   import spdc8_pkg::*;

   localparam int IDX_W = $clog2(BODY_LIMIT);
   localparam int TGT_W = $clog2(BODY_LIMIT + 1);
   localparam int SUM_W = 18;

   // Framing state
   phase_type        phase_ff, phase_in;
   logic [2:0]       hidx_ff, hidx_in;
   logic [7:0]       hdr_ff [HDR_DEPTH];
   logic [7:0]       hdr_in [HDR_DEPTH];
   logic [7:0]       crc_ff, crc_in;
   logic [IDX_W-1:0] bidx_ff, bidx_in;
   logic [TGT_W-1:0] btgt_ff, btgt_in;
   logic [7:0]       lead_ff [LEAD_DEPTH];
   logic [7:0]       lead_in [LEAD_DEPTH];

   // Result buffer: output register plus skid entry
   rsp_word_type     out_ff, out_in;
   logic             out_vld_ff, out_vld_in;
   rsp_word_type     skid_ff, skid_in;
   logic             skid_vld_ff, skid_vld_in;

   logic             req_accept;
   logic             rsp_pop;
   logic             push;
   logic [7:0]       b;
   logic [TGT_W-1:0] bidx_p1;
   logic [SUM_W-1:0] len_sum;
   rsp_word_type     new_word;

   assign b          = req_chan.rx_byte;
   assign req_chan.ready = ~skid_vld_ff;
   assign req_accept = req_chan.valid & ~skid_vld_ff;
   assign rsp_pop    = out_vld_ff & rsp_chan.ready;

   assign bidx_p1 = TGT_W'(bidx_ff) + TGT_W'(1);
   assign len_sum = SUM_W'({hdr_ff[0], hdr_ff[1]}) + SUM_W'(hdr_ff[2]) + SUM_W'(1);

   // Per-byte framing step
   always_comb begin
      phase_in = phase_ff;
      hidx_in  = hidx_ff;
      hdr_in   = hdr_ff;
      crc_in   = crc_ff;
      bidx_in  = bidx_ff;
      btgt_in  = btgt_ff;
      lead_in  = lead_ff;
      push     = 1'b0;
      if (req_accept) begin
         case (phase_ff)
            PH_HEADER: begin
               if (hidx_ff < 3'd4) begin
                  hdr_in[hidx_ff[1:0]] = b;
                  crc_in  = crc8_step(crc_ff, b);
                  hidx_in = hidx_ff + 3'd1;
               end else if (b != crc_ff) begin
                  // header CRC mismatch: back to hunting, silently
                  phase_in = PH_HUNT;
                  hidx_in  = 3'd0;
               end else begin
                  if (len_sum > SUM_W'(BODY_LIMIT)) begin
                     btgt_in = TGT_W'(BODY_LIMIT);
                  end else begin
                     btgt_in = len_sum[TGT_W-1:0];
                  end
                  bidx_in  = '0;
                  crc_in   = 8'h00;
                  phase_in = PH_BODY;
               end
            end
            PH_BODY: begin
               if (bidx_ff < IDX_W'(LEAD_DEPTH)) begin
                  lead_in[bidx_ff[LEAD_IW-1:0]] = b;
               end
               if (bidx_p1 < btgt_ff) begin
                  crc_in  = crc8_step(crc_ff, b);
                  bidx_in = bidx_ff + IDX_W'(1);
               end else begin
                  push     = 1'b1;
                  phase_in = PH_HUNT;
                  hidx_in  = 3'd0;
                  bidx_in  = '0;
                  crc_in   = 8'h00;
               end
            end
            default: begin
               // hunting; any other code acts the same
               if (b == SYNC_BYTE) begin
                  phase_in = PH_HEADER;
                  hidx_in  = 3'd0;
                  crc_in   = 8'h00;
                  for (int i = 0; i < HDR_DEPTH; i++) hdr_in[i] = 8'h00;
                  for (int i = 0; i < LEAD_DEPTH; i++) lead_in[i] = 8'h00;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
         endcase
      end
   end

   // Result word assembly from header and leading body bytes
   always_comb begin
      new_word                 = '0;
      new_word.packet_type     = hdr_ff[3];
      new_word.data_length     = {hdr_ff[0], hdr_ff[1]};
      new_word.optional_length = hdr_ff[2];
      new_word.body_crc_ok     = (b == crc_ff);
      if (hdr_ff[3] == TYPE_RADIO_ADV) begin
         new_word.radio_valid = 1'b1;
         new_word.radio_org   = lead_in[0];
         case (lead_in[0])
            ORG_TEACH: begin
               new_word.sender_id    = {lead_in[3], lead_in[4], lead_in[5], lead_in[6]};
               new_word.payload_word = {lead_in[7], lead_in[8], lead_in[9], lead_in[10]};
            end
            ORG_4BS: begin
               new_word.sender_id    = {lead_in[1], lead_in[2], lead_in[3], lead_in[4]};
               new_word.payload_word = {lead_in[5], lead_in[6], lead_in[7], lead_in[8]};
            end
            ORG_RPS: begin
               new_word.sender_id    = {lead_in[1], lead_in[2], lead_in[3], lead_in[4]};
               new_word.payload_word = {4'h0, lead_in[5][3:0] & RPS_DATA_MASK, 24'h0};
               new_word.repeat_bit   = lead_in[5][7];
            end
            default: begin
               new_word.sender_id    = {lead_in[1], lead_in[2], lead_in[3], lead_in[4]};
            end
         endcase
      end
   end

   // Output register and skid entry
   always_comb begin
      out_in      = out_ff;
      out_vld_in  = out_vld_ff;
      skid_in     = skid_ff;
      skid_vld_in = skid_vld_ff;
      if (skid_vld_ff) begin
         if (rsp_pop) begin
            out_in      = skid_ff;
            skid_vld_in = 1'b0;
         end
      end else if (push) begin
         if (out_vld_ff && !rsp_pop) begin
            skid_in     = new_word;
            skid_vld_in = 1'b1;
         end else begin
            out_in     = new_word;
            out_vld_in = 1'b1;
         end
      end else if (rsp_pop) begin
         out_vld_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT;
         hidx_ff     <= 3'd0;
         crc_ff      <= 8'h00;
         bidx_ff     <= '0;
         btgt_ff     <= '0;
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         hidx_ff     <= hidx_in;
         crc_ff      <= crc_in;
         bidx_ff     <= bidx_in;
         btgt_ff     <= btgt_in;
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      hdr_ff  <= hdr_in;
      lead_ff <= lead_in;
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid           = out_vld_ff;
   assign rsp_chan.packet_type     = out_ff.packet_type;
   assign rsp_chan.data_length     = out_ff.data_length;
   assign rsp_chan.optional_length = out_ff.optional_length;
   assign rsp_chan.body_crc_ok     = out_ff.body_crc_ok;
   assign rsp_chan.radio_valid     = out_ff.radio_valid;
   assign rsp_chan.radio_org       = out_ff.radio_org;
   assign rsp_chan.sender_id       = out_ff.sender_id;
   assign rsp_chan.payload_word    = out_ff.payload_word;
   assign rsp_chan.repeat_bit      = out_ff.repeat_bit;

   // Checks
   `SPDC8_ASSERT_NOW(a_skid_needs_out, clock, reset, skid_vld_ff, out_vld_ff, "skid word held while output register empty")
   `SPDC8_ASSERT_NOW(a_body_index_range, clock, reset, phase_ff == PH_BODY, (bidx_p1 <= btgt_ff) && (btgt_ff != '0), "body index outside packet body")
   `SPDC8_ASSERT_NOW(a_push_from_body, clock, reset, push, phase_ff == PH_BODY, "result produced outside body phase")
   `SPDC8_ASSERT_NEXT(a_hunt_after_result, clock, reset, push, (phase_ff == PH_HUNT) && out_vld_ff, "no hunt or no result after final body byte")

endmodule

// ----- tb/sv/serial_packet_deframer_crc8_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the serial packet deframer: byte stream in, decoded frames checked.
module serial_packet_deframer_crc8_tb;
   import spdc8_pkg::*;

   localparam int BODY_CAP     = BODY_LIMIT_DEFAULT;
   localparam int RANDOM_BYTES = 1330;
   localparam int CALM_TAIL    = 200;
   localparam int DRAIN_CYCLES = 16;

   typedef struct {
      logic [7:0] data;
      bit         drain_first;
   } pending_word_type;

   logic clock;
   logic reset;

   spdc8_req_if req_if();
   spdc8_rsp_if rsp_if();

   serial_packet_deframer_crc8 #(.BODY_LIMIT(BODY_CAP)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   pending_word_type tx_words[$];
   rsp_word_type  frames_due[$];
   int            mismatches = 0;
   bit            word_taken = 0;
   int            gap_left   = 0;
   int            stall_left = 0;

   // Deframer shadow state
   phase_type  fr_phase = PH_HUNT;
   int         fr_hdr_count = 0;
   logic [7:0] fr_hdr[HDR_DEPTH];
   logic [7:0] fr_crc = 8'h00;
   int         fr_body_count = 0;
   int         fr_body_len = 0;
   logic [7:0] fr_lead[LEAD_DEPTH];

   // CRC-8, poly 0x07, one data bit at a time, MSB first
   function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] d);
      logic [7:0] r;
      logic       fb;
      r = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = r[7] ^ d[i];
         r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      end
      return r;
   endfunction

   // Body bytes past the stored ones read as zero
   function automatic logic [7:0] lead_at(input int i);
      return (i < LEAD_DEPTH) ? fr_lead[i] : 8'h00;
   endfunction

   function automatic logic [31:0] lead_word(input int i);
      return {lead_at(i), lead_at(i + 1), lead_at(i + 2), lead_at(i + 3)};
   endfunction

   function automatic string frame_text(input rsp_word_type w);
      return $sformatf("type=%h dlen=%h olen=%h crc_ok=%b radio=%b org=%h id=%h pay=%h rep=%b",
                       w.packet_type, w.data_length, w.optional_length, w.body_crc_ok,
                       w.radio_valid, w.radio_org, w.sender_id, w.payload_word, w.repeat_bit);
   endfunction

   // Advance the shadow deframer by one accepted byte; a completed frame is queued
   task automatic deframe_byte(input logic [7:0] b);
      rsp_word_type w;
      logic [7:0]   rps_byte;
      int           len;
      case (fr_phase)
         PH_HEADER: begin
            if (fr_hdr_count < HDR_DEPTH) begin
               fr_hdr[fr_hdr_count] = b;
               fr_crc = crc8_next(fr_crc, b);
               fr_hdr_count++;
            end else if (b != fr_crc) begin
               // bad header CRC: back to sync hunting, silently
               fr_phase = PH_HUNT;
               fr_hdr_count = 0;
            end else begin
               len = {fr_hdr[0], fr_hdr[1]} + fr_hdr[2] + 1;
               if (len > BODY_CAP) len = BODY_CAP;
               fr_body_len = len;
               fr_body_count = 0;
               fr_crc = 8'h00;
               fr_phase = PH_BODY;
            end
         end
         PH_BODY: begin
            if (fr_body_count < LEAD_DEPTH) fr_lead[fr_body_count] = b;
            if (fr_body_count + 1 < fr_body_len) begin
               fr_crc = crc8_next(fr_crc, b);
               fr_body_count++;
            end else begin
               w = '0;
               w.packet_type     = fr_hdr[3];
               w.data_length     = {fr_hdr[0], fr_hdr[1]};
               w.optional_length = fr_hdr[2];
               w.body_crc_ok     = (b == fr_crc);
               if (fr_hdr[3] == TYPE_RADIO_ADV) begin
                  w.radio_valid = 1'b1;
                  w.radio_org   = lead_at(0);
                  case (w.radio_org)
                     ORG_TEACH: begin
                        w.sender_id    = lead_word(3);
                        w.payload_word = lead_word(7);
                     end
                     ORG_4BS: begin
                        w.sender_id    = lead_word(1);
                        w.payload_word = lead_word(5);
                     end
                     ORG_RPS: begin
                        rps_byte       = lead_at(5);
                        w.sender_id    = lead_word(1);
                        w.payload_word = {4'h0, rps_byte[3:0] & RPS_DATA_MASK, 24'h000000};
                        w.repeat_bit   = rps_byte[7];
                     end
                     default: w.sender_id = lead_word(1);
                  endcase
               end
               frames_due.push_back(w);
               fr_phase = PH_HUNT;
               fr_hdr_count = 0;
               fr_body_count = 0;
               fr_crc = 8'h00;
            end
         end
         default: begin
            if (b == SYNC_BYTE) begin
               fr_phase = PH_HEADER;
               fr_hdr_count = 0;
               fr_crc = 8'h00;
               foreach (fr_hdr[i]) fr_hdr[i] = 8'h00;
               foreach (fr_lead[i]) fr_lead[i] = 8'h00;
            end else begin
               fr_phase = PH_HUNT;
            end
         end
      endcase
   endtask

   task automatic queue_word(input logic [7:0] b, input bit drain = 1'b0);
      pending_word_type p;
      p.data = b;
      p.drain_first = drain;
      tx_words.push_back(p);
   endtask

   // Sync, header, header CRC; if not hdr_bad, body closed by its CRC; head seeds first body bytes
   task automatic queue_frame(input logic [7:0] ptype, input logic [15:0] dlen,
                              input logic [7:0] olen, input logic [7:0] head[$],
                              input bit hdr_bad, input bit body_bad, input bit drain);
      logic [7:0] hdr[HDR_DEPTH];
      logic [7:0] crc;
      logic [7:0] b;
      int         len;
      hdr = '{dlen[15:8], dlen[7:0], olen, ptype};
      queue_word(SYNC_BYTE, drain);
      crc = 8'h00;
      foreach (hdr[i]) begin
         queue_word(hdr[i]);
         crc = crc8_next(crc, hdr[i]);
      end
      if (hdr_bad) begin
         queue_word(crc ^ 8'($urandom_range(1, 255)));
      end else begin
         queue_word(crc);
         len = dlen + olen + 1;
         if (len > BODY_CAP) len = BODY_CAP;
         crc = 8'h00;
         for (int i = 0; i < len - 1; i++) begin
            b = (i < head.size()) ? head[i] : 8'($urandom);
            queue_word(b);
            crc = crc8_next(crc, b);
         end
         queue_word(body_bad ? crc ^ 8'($urandom_range(1, 255)) : crc);
      end
   endtask

   // Mostly well-formed frames with random content, some noise and broken ones
   task automatic queue_random_frame(input bit drain);
      logic [7:0]  head[$];
      logic [7:0]  ptype;
      logic [7:0]  olen;
      logic [15:0] dlen;
      int          kind;
      int          pick;
      kind = $urandom_range(0, 99);
      if ($urandom_range(0, 6) == 0) begin
         repeat ($urandom_range(1, 4)) queue_word(8'($urandom));
      end
      if (kind >= 95) begin
         // truncated frame: sync and part of a header
         queue_word(SYNC_BYTE, drain);
         repeat ($urandom_range(0, 4)) queue_word(8'($urandom));
      end else begin
         ptype = ($urandom_range(0, 1) == 0) ? TYPE_RADIO_ADV : 8'($urandom);
         pick = $urandom_range(0, 3);
         case (pick)
            0:       head = {ORG_TEACH};
            1:       head = {ORG_RPS};
            2:       head = {ORG_4BS};
            default: head = {8'($urandom)};
         endcase
         dlen = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 14));
         olen = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 7)) : 8'($urandom);
         queue_frame(ptype, dlen, olen, head, kind < 8, kind >= 8 && kind < 18, drain);
      end
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Timeout
   initial begin
      #4ms;
      $display("CHECK FAILED");
      $finish;
   end

   // Byte driver: presents the next pending word on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || word_taken) begin
         if (gap_left > 0) begin
            req_if.valid <= 1'b0;
            gap_left--;
         end else if (tx_words.size() > 0 &&
                      !(tx_words[0].drain_first && frames_due.size() > 0)) begin
            req_if.valid   <= 1'b1;
            req_if.rx_byte <= tx_words[0].data;
            tx_words.pop_front();
            if (tx_words.size() >= CALM_TAIL && $urandom_range(0, 9) == 0)
               gap_left = $urandom_range(1, 6);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Result side ready, stalled in bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_if.ready <= 1'b1;
         if (tx_words.size() >= CALM_TAIL && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 6);
      end
   end

   // Monitor: check results first, then feed accepted bytes to the shadow deframer
   always @(posedge clock) begin
      rsp_word_type got;
      rsp_word_type want;
      word_taken = 1'b0;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.packet_type     = rsp_if.packet_type;
            got.data_length     = rsp_if.data_length;
            got.optional_length = rsp_if.optional_length;
            got.body_crc_ok     = rsp_if.body_crc_ok;
            got.radio_valid     = rsp_if.radio_valid;
            got.radio_org       = rsp_if.radio_org;
            got.sender_id       = rsp_if.sender_id;
            got.payload_word    = rsp_if.payload_word;
            got.repeat_bit      = rsp_if.repeat_bit;
            if (frames_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result at %0t: %s", $realtime, frame_text(got));
            end else begin
               want = frames_due.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("result mismatch at %0t", $realtime);
                     $display("  expected %s", frame_text(want));
                     $display("  actual   %s", frame_text(got));
                  end
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            word_taken = 1'b1;
            deframe_byte(req_if.rx_byte);
         end
      end
   end

   // Stimulus and end of run
   initial begin
      logic [7:0] no_head[$];
      logic [7:0] head[$];
      int         target;
      int         frame_count;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.rx_byte = 8'h00;
      rsp_if.ready = 1'b0;
      foreach (fr_hdr[i]) fr_hdr[i] = 8'h00;
      foreach (fr_lead[i]) fr_lead[i] = 8'h00;

      // RPS telegram: repeater bit set, data nibble only
      head = {ORG_RPS, 8'hFE, 8'hDC, 8'hBA, 8'h98, 8'hF7, 8'h81};
      queue_frame(TYPE_RADIO_ADV, 16'd7, 8'd0, head, 1'b0, 1'b0, 1'b0);
      // 4BS with optional bytes
      head = {ORG_4BS, 8'h01, 8'h02, 8'h03, 8'h04, 8'h55, 8'hAA, 8'h00, 8'hFF};
      queue_frame(TYPE_RADIO_ADV, 16'd10, 8'd7, head, 1'b0, 1'b0, 1'b0);
      // teach-in, full length
      head = {ORG_TEACH, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'hC3, 8'h3C, 8'h96, 8'h69};
      queue_frame(TYPE_RADIO_ADV, 16'd11, 8'd7, head, 1'b0, 1'b0, 1'b0);
      // unknown org, short body
      head = {8'hD5, 8'h11};
      queue_frame(TYPE_RADIO_ADV, 16'd2, 8'd0, head, 1'b0, 1'b0, 1'b0);
      // teach-in cut short: missing body bytes decode as zero
      head = {ORG_TEACH, 8'h12, 8'h34, 8'h56};
      queue_frame(TYPE_RADIO_ADV, 16'd4, 8'd0, head, 1'b0, 1'b0, 1'b0);
      // single-byte body, checked against the CRC of nothing
      queue_frame(8'h01, 16'h0000, 8'h00, no_head, 1'b0, 1'b0, 1'b0);
      queue_frame(8'h02, 16'h0000, 8'h00, no_head, 1'b0, 1'b1, 1'b0);
      // noise while hunting
      queue_word(8'h00);
      queue_word(8'hFF);
      queue_word(8'hAA);
      queue_word(8'h54);
      queue_word(8'h56);
      // header CRC mismatch
      queue_frame(TYPE_RADIO_ADV, 16'd7, 8'd0, no_head, 1'b1, 1'b0, 1'b0);
      // sync value inside header and body
      head = {SYNC_BYTE, SYNC_BYTE};
      queue_frame(SYNC_BYTE, 16'h0002, 8'h00, head, 1'b0, 1'b0, 1'b0);
      // oversize lengths saturate at the body limit
      queue_frame(8'hFF, 16'hFFFF, 8'h55, no_head, 1'b0, 1'b0, 1'b0);
      head = {ORG_4BS};
      queue_frame(TYPE_RADIO_ADV, 16'h0000, 8'hFF, head, 1'b0, 1'b0, 1'b0);
      // bad body CRC on a radio frame, sent only once the pipe has drained
      head = {ORG_RPS};
      queue_frame(TYPE_RADIO_ADV, 16'd7, 8'd0, head, 1'b0, 1'b1, 1'b1);

      target = tx_words.size() + RANDOM_BYTES;
      frame_count = 0;
      while (tx_words.size() < target) begin
         queue_random_frame(frame_count % 40 == 39);
         frame_count++;
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (tx_words.size() != 0 || req_if.valid) @(posedge clock);
      while (frames_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+design
design/spdc8_pkg.sv
design/spdc8_intf.sv
design/serial_packet_deframer_crc8.sv
tb/sv/serial_packet_deframer_crc8_tb.sv
